@@ src/nbs_pkg.sv @@
// Shared types for the nested box suppression block.
`timescale 1ns / 1ps

package nbs_pkg;

    // Input item: one box, last box of the set marked by final_box
    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic signed [15:0] right_x;
        logic signed [15:0] bottom_y;
        logic               final_box;
    } box_item_t;

    // Result item: one kept box
    typedef struct packed {
        logic signed [15:0] kept_left;
        logic signed [15:0] kept_top;
        logic signed [15:0] kept_right;
        logic signed [15:0] kept_bottom;
        logic               none_kept;
        logic               overflowed;
        logic               end_of_set;
    } kept_item_t;

    // Box as held in a cell, with its precomputed center
    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic signed [15:0] right_x;
        logic signed [15:0] bottom_y;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } box_rec_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_TEST,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

endpackage

@@ src/nested_box_suppression_core.sv @@
// Top level: box ring of cells, set sequencer and output register.
// Load: one box per cycle, accepted whenever the block is in its load phase.
// After the final box, each stored box passes a cell test and a decide step as the ring
// rotates it to the head; a flush step then closes the set once the output is free.
// A kept box waits for a later one, so results trail their test by one decision.
// Reset clears count, flags and sequencer; cell contents stay undefined (no clearing pass).
`timescale 1ns / 1ps

module nested_box_suppression_core #(
    parameter int MAX_BOXES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                box_valid,
    output logic                box_stall,
    input  nbs_pkg::box_item_t  box,
    output logic                kept_valid,
    input  logic                kept_stall,
    output nbs_pkg::kept_item_t kept
);
    import nbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [IDX_W-1:0]     rot_reg, rot_next;
    logic                 pend_valid_reg, pend_valid_next;
    box_rec_t             pend_reg, pend_next;
    logic                 kept_valid_reg, kept_valid_next;
    kept_item_t           kept_reg, kept_next;
    logic [MAX_BOXES-1:0] hit_reg, hit_next;

    cell_ctrl_t           ctrl;
    box_rec_t             wr_box;
    box_rec_t             held [MAX_BOXES];
    logic [MAX_BOXES-1:0] hit_vec;
    logic                 accept;
    logic                 out_free;
    logic                 nested;
    logic                 last_box;
    logic                 advance;

    // (a + b) / 2 truncating toward zero; sum held at 17 bits
    function automatic logic signed [15:0] half_sum(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic signed [16:0] s;
        logic signed [16:0] adj;
        s   = 17'(a) + 17'(b);
        adj = s + 17'(s[16]);
        return adj[16:1];
    endfunction

    assign wr_box.left_x   = box.left_x;
    assign wr_box.top_y    = box.top_y;
    assign wr_box.right_x  = box.right_x;
    assign wr_box.bottom_y = box.bottom_y;
    assign wr_box.cx       = half_sum(box.left_x, box.right_x);
    assign wr_box.cy       = half_sum(box.top_y, box.bottom_y);

    genvar k;
    generate
        for (k = 0; k < MAX_BOXES; k++)
        begin : g_cell
            localparam int NXT = (k + 1) % MAX_BOXES;
            nbs_cell #(
                .MAX_BOXES (MAX_BOXES),
                .CELL_IDX  (k),
                .CNT_W     (CNT_W),
                .IDX_W     (IDX_W)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .count    (count_reg),
                .rot      (rot_reg),
                .wr_box   (wr_box),
                .nbr      (held[NXT]),
                .probe_cx (held[0].cx),
                .probe_cy (held[0].cy),
                .held     (held[k]),
                .hit      (hit_vec[k])
            );
        end
    endgenerate

    assign box_stall  = (state_reg != ST_LOAD);
    assign accept     = box_valid && !box_stall;
    assign out_free   = !kept_valid_reg || !kept_stall;
    assign nested     = |hit_reg;
    assign last_box   = (CNT_W'(rot_reg) + 1'b1) == count_reg;
    assign advance    = nested || !pend_valid_reg || out_free;
    assign kept_valid = kept_valid_reg;
    assign kept       = kept_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        rot_next        = rot_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        kept_next       = kept_reg;
        kept_valid_next = kept_valid_reg && kept_stall;
        ctrl            = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_BOXES))
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (box.final_box)
                    begin
                        state_next      = ST_TEST;
                        rot_next        = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end

            ST_TEST:
            begin
                hit_next   = hit_vec;
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (advance)
                begin
                    if (!nested)
                    begin
                        // previous survivor is not the last one: send it on
                        if (pend_valid_reg)
                        begin
                            kept_next.kept_left   = pend_reg.left_x;
                            kept_next.kept_top    = pend_reg.top_y;
                            kept_next.kept_right  = pend_reg.right_x;
                            kept_next.kept_bottom = pend_reg.bottom_y;
                            kept_next.none_kept   = 1'b0;
                            kept_next.overflowed  = ovf_reg;
                            kept_next.end_of_set  = 1'b0;
                            kept_valid_next       = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = held[0];
                    end
                    if (last_box)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        ctrl.rotate = 1'b1;
                        rot_next    = rot_reg + 1'b1;
                        state_next  = ST_TEST;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        kept_next.kept_left   = pend_reg.left_x;
                        kept_next.kept_top    = pend_reg.top_y;
                        kept_next.kept_right  = pend_reg.right_x;
                        kept_next.kept_bottom = pend_reg.bottom_y;
                        kept_next.none_kept   = 1'b0;
                    end
                    else
                    begin
                        kept_next.kept_left   = '0;
                        kept_next.kept_top    = '0;
                        kept_next.kept_right  = '0;
                        kept_next.kept_bottom = '0;
                        kept_next.none_kept   = 1'b1;
                    end
                    kept_next.overflowed = ovf_reg;
                    kept_next.end_of_set = 1'b1;
                    kept_valid_next      = 1'b1;
                    pend_valid_next      = 1'b0;
                    count_next           = '0;
                    ovf_next             = 1'b0;
                    rot_next             = '0;
                    state_next           = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            rot_reg        <= '0;
            pend_valid_reg <= 1'b0;
            kept_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            rot_reg        <= rot_next;
            pend_valid_reg <= pend_valid_next;
            kept_valid_reg <= kept_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        kept_reg <= kept_next;
        hit_reg  <= hit_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count above capacity");

    a_rot_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST || state_reg == ST_DECIDE) |-> CNT_W'(rot_reg) < count_reg)
        else $error("ring head beyond stored boxes");

    a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && out_free) |=>
            (state_reg == ST_LOAD && count_reg == '0 && kept_valid && kept.end_of_set))
        else $error("set not closed with end_of_set item");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_valid && kept.none_kept) |->
            (kept.end_of_set && kept.kept_left == '0 && kept.kept_bottom == '0))
        else $error("empty result item malformed");

    a_no_pending_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !pend_valid_reg)
        else $error("survivor left pending after set closed");
`endif

endmodule

@@ src/nbs_cell.sv @@
// One storage cell of the box ring: holds a box and tests a probe center against it.
`timescale 1ns / 1ps

module nbs_cell #(
    parameter int MAX_BOXES = 32,
    parameter int CELL_IDX  = 0,
    parameter int CNT_W     = $clog2(MAX_BOXES + 1),
    parameter int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
    input  logic                clk,
    input  nbs_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [IDX_W-1:0]    rot,
    input  nbs_pkg::box_rec_t   wr_box,
    input  nbs_pkg::box_rec_t   nbr,
    input  logic signed [15:0]  probe_cx,
    input  logic signed [15:0]  probe_cy,
    output nbs_pkg::box_rec_t   held,
    output logic                hit
);
    import nbs_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    box_rec_t         rec_reg;
    box_rec_t         rec_next;
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] pos_wrap;
    logic             occupied;
    logic             same_center;
    logic             enclosed;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.rotate)
        begin
            rec_next = nbr;
        end
        else if (ctrl.load && (count == CNT_W'(CELL_IDX)))
        begin
            rec_next = wr_box;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // load-order slot currently sitting in this cell
    assign pos_sum  = SUM_W'(rot) + SUM_W'(CELL_IDX);
    assign pos_wrap = (pos_sum >= SUM_W'(MAX_BOXES)) ? (pos_sum - SUM_W'(MAX_BOXES)) : pos_sum;
    assign occupied = pos_wrap < SUM_W'(count);

    assign same_center = (rec_reg.cx == probe_cx) && (rec_reg.cy == probe_cy);
    assign enclosed    = (probe_cx > rec_reg.left_x) && (probe_cx < rec_reg.right_x) &&
                         (probe_cy > rec_reg.top_y)  && (probe_cy < rec_reg.bottom_y);

    assign hit  = occupied && !same_center && enclosed;
    assign held = rec_reg;

endmodule

@@ sim/nbs_box_checker.sv @@
// Checker for nested box suppression: predicts kept boxes per set and compares results.
`timescale 1ns / 1ps

module nbs_box_checker #(
    parameter int MAX_BOXES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                box_valid,
    input  logic                box_stall,
    input  nbs_pkg::box_item_t  box,
    input  logic                kept_valid,
    input  logic                kept_stall,
    input  nbs_pkg::kept_item_t kept,
    output int                  mismatches,
    output int                  pending
);
    import nbs_pkg::*;

    box_item_t  held [MAX_BOXES];
    int         lx [MAX_BOXES];
    int         ty [MAX_BOXES];
    int         rx [MAX_BOXES];
    int         by [MAX_BOXES];
    int         held_n;
    logic       dropped_any;
    kept_item_t kept_q [$];
    kept_item_t want;

    function automatic int to_int(logic signed [15:0] v);
        return int'(v);
    endfunction

    // int sum, halved toward zero
    function automatic int mid(int a, int b);
        return (a + b) / 2;
    endfunction

    function automatic bit is_covered(int idx);
        int cx;
        int cy;
        cx = mid(lx[idx], rx[idx]);
        cy = mid(ty[idx], by[idx]);
        for (int j = 0; j < held_n; j++)
        begin
            // boxes sharing the tested center (itself included) never cover it
            if (mid(lx[j], rx[j]) == cx && mid(ty[j], by[j]) == cy)
                continue;
            if (cx > lx[j] && cx < rx[j] && cy > ty[j] && cy < by[j])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic take_box(box_item_t b);
        bit         keep [MAX_BOXES];
        int         last_kept;
        kept_item_t r;
        if (held_n < MAX_BOXES)
        begin
            held[held_n] = b;
            lx[held_n]   = to_int(b.left_x);
            ty[held_n]   = to_int(b.top_y);
            rx[held_n]   = to_int(b.right_x);
            by[held_n]   = to_int(b.bottom_y);
            held_n++;
        end
        else
            dropped_any = 1'b1;
        if (b.final_box)
        begin
            last_kept = -1;
            for (int i = 0; i < held_n; i++)
            begin
                keep[i] = !is_covered(i);
                if (keep[i])
                    last_kept = i;
            end
            if (last_kept < 0)
            begin
                r            = '0;
                r.none_kept  = 1'b1;
                r.overflowed = dropped_any;
                r.end_of_set = 1'b1;
                kept_q = {kept_q, r};
            end
            else
            begin
                for (int i = 0; i < held_n; i++)
                begin
                    if (keep[i])
                    begin
                        r             = '0;
                        r.kept_left   = held[i].left_x;
                        r.kept_top    = held[i].top_y;
                        r.kept_right  = held[i].right_x;
                        r.kept_bottom = held[i].bottom_y;
                        r.overflowed  = dropped_any;
                        r.end_of_set  = (i == last_kept);
                        kept_q = {kept_q, r};
                    end
                end
            end
            held_n      = 0;
            dropped_any = 1'b0;
        end
    endtask

    task automatic note_fail(string what, kept_item_t exp_r, kept_item_t got_r);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%0t %s: expected %0d %0d %0d %0d none=%0b ovf=%0b last=%0b, ",
                   $realtime, what,
                   to_int(exp_r.kept_left), to_int(exp_r.kept_top),
                   to_int(exp_r.kept_right), to_int(exp_r.kept_bottom),
                   exp_r.none_kept, exp_r.overflowed, exp_r.end_of_set);
            $display("got %0d %0d %0d %0d none=%0b ovf=%0b last=%0b",
                     to_int(got_r.kept_left), to_int(got_r.kept_top),
                     to_int(got_r.kept_right), to_int(got_r.kept_bottom),
                     got_r.none_kept, got_r.overflowed, got_r.end_of_set);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_n      = 0;
            dropped_any = 1'b0;
            kept_q.delete();
            pending     = 0;
            mismatches  = 0;
        end
        else
        begin
            if (kept_valid && !kept_stall)
            begin
                if (kept_q.size() == 0)
                    note_fail("unexpected result", '0, kept);
                else
                begin
                    want = kept_q.pop_front();
                    if (kept.kept_left   !== want.kept_left   ||
                        kept.kept_top    !== want.kept_top    ||
                        kept.kept_right  !== want.kept_right  ||
                        kept.kept_bottom !== want.kept_bottom ||
                        kept.none_kept   !== want.none_kept   ||
                        kept.overflowed  !== want.overflowed  ||
                        kept.end_of_set  !== want.end_of_set)
                        note_fail("wrong result", want, kept);
                end
            end
            if (box_valid && !box_stall)
                take_box(box);
            pending = kept_q.size();
        end
    end

endmodule

@@ sim/nested_box_suppression_core_tb.sv @@
// Testbench top for nested box suppression: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps

module nested_box_suppression_core_tb;
    import nbs_pkg::*;

    localparam int MAX_BOXES    = 32;
    localparam int ITEM_TARGET  = 370;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       box_valid;
    logic       box_stall;
    box_item_t  box;
    logic       kept_valid;
    logic       kept_stall;
    kept_item_t kept;
    logic       hold_req;
    int         mismatches;
    int         pending;
    int         quiet_cycles = 0;
    int         burst_left = 0;

    always #5 clk = ~clk;

    nested_box_suppression_core #(
        .MAX_BOXES (MAX_BOXES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_stall  (box_stall),
        .box        (box),
        .kept_valid (kept_valid),
        .kept_stall (kept_stall),
        .kept       (kept)
    );

    nbs_box_checker #(
        .MAX_BOXES (MAX_BOXES)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_stall  (box_stall),
        .box        (box),
        .kept_valid (kept_valid),
        .kept_stall (kept_stall),
        .kept       (kept),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic box_item_t make_box(int l, int t, int r, int b, bit fin);
        box_item_t item;
        item.left_x    = 16'(l);
        item.top_y     = 16'(t);
        item.right_x   = 16'(r);
        item.bottom_y  = 16'(b);
        item.final_box = fin;
        return item;
    endfunction

    // sender works in bursts; a gap is inserted only at the start of a burst
    task automatic send_box(box_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                box_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        box       <= item;
        box_valid <= 1'b1;
        @(posedge clk);
        while (box_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        box_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: stall density changes per stretch, plus one long hold-off on request
    initial
    begin
        int stretch;
        int pct;
        bit hold_done;
        hold_done = 1'b0;
        kept_stall <= 1'b0;
        forever
        begin
            stretch = $urandom_range(8, 60);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 50;
                default: pct = 80;
            endcase
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    hold_done = 1'b1;
                    kept_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                kept_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((box_valid && !box_stall) || (kept_valid && !kept_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int set_no;
        int kind;
        int n;
        int ox;
        int oy;
        int w;
        int h;
        int l;
        int t;
        box_item_t b;
        rst_n     <= 1'b0;
        box_valid <= 1'b0;
        box       <= '0;
        hold_req  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-range single boxes
        send_box(make_box(-32768, -32768, 32767, 32767, 1'b1));
        send_box(make_box(32767, -32768, -32768, 32767, 1'b1));
        // inverted box and point box sharing center zero
        send_box(make_box(32767, 32767, -32768, -32768, 1'b0));
        send_box(make_box(0, 0, 0, 0, 1'b1));
        // each center inside the other: nothing kept
        send_box(make_box(0, 0, 10, 10, 1'b0));
        send_box(make_box(4, 4, 8, 8, 1'b1));
        // three boxes with the same center all survive
        send_box(make_box(0, 0, 10, 10, 1'b0));
        send_box(make_box(2, 2, 8, 8, 1'b0));
        send_box(make_box(-3, -3, 13, 13, 1'b1));
        // small box inside a large one is dropped
        send_box(make_box(-100, -100, 100, 100, 1'b0));
        send_box(make_box(10, 10, 20, 20, 1'b1));
        // negative odd sum: halving truncates toward zero
        send_box(make_box(-3, -3, 0, 0, 1'b0));
        send_box(make_box(-2, -2, 6, 6, 1'b1));
        // center on an edge is not strictly inside
        send_box(make_box(0, 0, 10, 10, 1'b0));
        send_box(make_box(5, 0, 20, 10, 1'b1));
        send_box(make_box(-1, -1, -1, -1, 1'b0));
        send_box(make_box(-32768, 32767, 32767, -32768, 1'b1));
        drain_results();

        sent   = 0;
        set_no = 0;
        while (sent < ITEM_TARGET)
        begin
            if (set_no == 4)
                hold_req <= 1'b1;
            if (set_no == 12)
                drain_results();
            kind = $urandom_range(0, 99);
            if (kind < 55)
                n = $urandom_range(1, 8);
            else if (kind < 70)
                n = $urandom_range(1, 6);
            else if (kind < 82)
                n = $urandom_range(2, 6);
            else if (kind < 94)
                n = $urandom_range(9, MAX_BOXES);
            else
                n = $urandom_range(MAX_BOXES + 1, MAX_BOXES + 8);
            // make sure the store overflows, once with only the final box dropped
            if (set_no == 2 || set_no == 7)
            begin
                kind = 99;
                n    = (set_no == 2) ? MAX_BOXES + 1 : MAX_BOXES + 8;
            end
            ox = int'($urandom_range(0, 60000)) - 30000;
            oy = int'($urandom_range(0, 60000)) - 30000;
            for (int k = 0; k < n; k++)
            begin
                if (kind >= 55 && kind < 70)
                    b = make_box($urandom(), $urandom(), $urandom(), $urandom(), k == n - 1);
                else if (kind >= 70 && kind < 82)
                begin
                    // shared center, odd extents shift it when negative
                    w = $urandom_range(0, 60);
                    h = $urandom_range(0, 60);
                    b = make_box(ox - w, oy - h, ox + w + int'($urandom_range(0, 1)),
                                 oy + h + int'($urandom_range(0, 1)), k == n - 1);
                end
                else
                begin
                    l = ox + int'($urandom_range(0, 80)) - 40;
                    t = oy + int'($urandom_range(0, 80)) - 40;
                    b = make_box(l, t, l + int'($urandom_range(0, 80)),
                                 t + int'($urandom_range(0, 80)), k == n - 1);
                end
                send_box(b);
                sent++;
            end
            set_no++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
src/nbs_pkg.sv
src/nbs_cell.sv
src/nested_box_suppression_core.sv
sim/nbs_box_checker.sv
sim/nested_box_suppression_core_tb.sv
